[sv/modified_utf8_validator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modified UTF-8 validator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_UTF8_VALIDATOR_DEFINES_SVH
`define MODIFIED_UTF8_VALIDATOR_DEFINES_SVH

`ifndef SYNTH

// Check that cond never holds outside reset.
`define UMV_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// Check that ante implies cons in the same cycle.
`define UMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that ante implies cons in the next cycle.
`define UMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UMV_ASSERT_NEVER(label, clk, rst_n, cond)
`define UMV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UMV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/umv_pkg.sv]
// ----------------------------------------------------------------------------
// umv_pkg
// Types and constants shared by the modified UTF-8 validator files.
// ----------------------------------------------------------------------------
package umv_pkg;

  // continuation bytes look like 10xxxxxx
  localparam logic [7:0] ContMask = 8'hc0;
  localparam logic [7:0] ContTag  = 8'h80;

  // high nibble of a three-byte lead
  localparam logic [3:0] Lead3Nibble = 4'he;
  // high three bits of a two-byte lead
  localparam logic [2:0] Lead2Bits   = 3'b110;

  typedef enum logic [1:0] {
    STATUS_CLEAN         = 2'd0,
    STATUS_ILLEGAL_START = 2'd1,
    STATUS_BAD_CONT      = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    status_e    end_status;
  } result_t;

  // results caused by one input byte, lowest index first
  typedef struct packed {
    logic [1:0]       count;
    result_t [2:0]    res;
  } step_out_t;

  typedef struct packed {
    logic [1:0] need_count;
    logic [1:0] held_count;
    logic       discarding;
  } step_state_t;

endpackage

[sv/umv_in_if.sv]
// ----------------------------------------------------------------------------
// umv_in_if
// Byte request channel into the validator.
// ----------------------------------------------------------------------------
interface umv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[sv/umv_out_if.sv]
// ----------------------------------------------------------------------------
// umv_out_if
// Result request channel out of the validator.
// ----------------------------------------------------------------------------
interface umv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_end;
  logic [1:0] end_status;

  modport source (output valid, output out_byte, output is_end, output end_status,
                  input ready);
  modport sink   (input valid, input out_byte, input is_end, input end_status,
                  output ready);
endinterface

[sv/umv_step.sv]
// ----------------------------------------------------------------------------
// umv_step
// Character state and decode: one byte in, zero to three results out.
// ----------------------------------------------------------------------------
module umv_step
  import umv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [7:0]  byte_i,
  output step_out_t   push_o,
  output step_state_t state_o
);

  logic [1:0] need_q, need_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic       disc_q, disc_d;
  logic [7:0] held_q [2];
  logic [7:0] held_d [2];
  logic       is_cont;

  assign is_cont = (byte_i & ContMask) == ContTag;

  always_comb begin
    need_d     = need_q;
    held_cnt_d = held_cnt_q;
    disc_d     = disc_q;
    held_d[0]  = held_q[0];
    held_d[1]  = held_q[1];
    push_o     = '0;
    if (en_i) begin
      priority if (disc_q) begin
        if (byte_i == 8'h00) disc_d = 1'b0;
      end else if (need_q != 2'd0) begin
        priority if (!is_cont) begin
          // drop the whole pending character
          need_d                   = 2'd0;
          held_cnt_d               = 2'd0;
          push_o.count             = 2'd1;
          push_o.res[0].is_end     = 1'b1;
          push_o.res[0].end_status = STATUS_BAD_CONT;
          disc_d                   = byte_i != 8'h00;
        end else if (need_q == 2'd2) begin
          held_d[1]  = byte_i;
          held_cnt_d = 2'd2;
          need_d     = 2'd1;
        end else begin
          // release the character, lead byte first
          push_o.res[0].out_byte = held_q[0];
          if (held_cnt_q == 2'd2) begin
            push_o.res[1].out_byte = held_q[1];
            push_o.res[2].out_byte = byte_i;
          end else begin
            push_o.res[1].out_byte = byte_i;
          end
          push_o.count = held_cnt_q + 2'd1;
          need_d       = 2'd0;
          held_cnt_d   = 2'd0;
        end
      end else if (byte_i == 8'h00) begin
        push_o.count             = 2'd1;
        push_o.res[0].is_end     = 1'b1;
        push_o.res[0].end_status = STATUS_CLEAN;
      end else if (!byte_i[7]) begin
        push_o.count           = 2'd1;
        push_o.res[0].out_byte = byte_i;
      end else if (byte_i[7:5] == Lead2Bits) begin
        held_d[0]  = byte_i;
        held_cnt_d = 2'd1;
        need_d     = 2'd1;
      end else if (byte_i[7:4] == Lead3Nibble) begin
        held_d[0]  = byte_i;
        held_cnt_d = 2'd1;
        need_d     = 2'd2;
      end else begin
        push_o.count             = 2'd1;
        push_o.res[0].is_end     = 1'b1;
        push_o.res[0].end_status = STATUS_ILLEGAL_START;
        disc_d                   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q     <= 2'd0;
      held_cnt_q <= 2'd0;
      disc_q     <= 1'b0;
    end else begin
      need_q     <= need_d;
      held_cnt_q <= held_cnt_d;
      disc_q     <= disc_d;
    end
  end

  // held bytes are only read below the held count
  always_ff @(posedge clk_i) begin
    held_q[0] <= held_d[0];
    held_q[1] <= held_d[1];
  end

  assign state_o.need_count = need_q;
  assign state_o.held_count = held_cnt_q;
  assign state_o.discarding = disc_q;

endmodule

[sv/modified_utf8_validator.sv]
// ----------------------------------------------------------------------------
// modified_utf8_validator
// Validates zero-terminated modified UTF-8 strings, truncating at a bad char.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one byte per request; a zero byte ends a string. out_o
//   carries the kept bytes of each string followed by one end marker whose
//   end_status tells clean end, illegal start byte or bad continuation.
//   After a bad character the rest of the string through its zero byte is
//   dropped with no results.
// Data path and throughput:
//   A byte is held in the input register, is decoded and its 0 to 3
//   results enter an output queue of QueueDepth entries; the first result is
//   valid once it is written into the queue. A byte is taken every cycle
//   while the queue holds at most QueueDepth-3 results. With a consumer that
//   takes one result per cycle the queue never holds more than three, since
//   every release is preceded by a lead byte that gives no result, so the
//   default depth of six accepts one byte per cycle with no stall.
// Reset:
//   Clears the character state, the input register and the queue.
// Stall:
//   When out_o.ready is low results wait in the queue; once it fills past
//   QueueDepth-3 the input register holds and in_i.ready drops.
// ----------------------------------------------------------------------------
`include "modified_utf8_validator_defines.svh"

module modified_utf8_validator
  import umv_pkg::*;
#(
  parameter int unsigned QueueDepth = 6  // 3 and up
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  umv_in_if.sink     in_i,
  umv_out_if.source  out_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  function automatic logic [PtrW-1:0] wrap(input logic [PtrW:0] s);
    logic [PtrW:0] r;
    r = s;
    if (s >= (PtrW+1)'(QueueDepth)) r = s - (PtrW+1)'(QueueDepth);
    return r[PtrW-1:0];
  endfunction

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            advance;
  logic            pop;
  step_out_t       push;
  step_state_t     st;

  result_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_idx [3];

  // ---------------- input register ----------------
  assign advance    = in_vld_q && (count_q <= CntW'(QueueDepth - 3));
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_byte_q <= in_i.data_byte;
  end

  // ---------------- decode ----------------
  umv_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .byte_i  (in_byte_q),
    .push_o  (push),
    .state_o (st)
  );

  // ---------------- result queue ----------------
  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_idx[k] = wrap({1'b0, wr_ptr_q} + (PtrW+1)'(k));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.count) mem_q[wr_idx[k]] <= push.res[k];
    end
  end

  assign count_d = count_q + CntW'(push.count) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wrap({1'b0, wr_ptr_q} + (PtrW+1)'(push.count));
      if (pop) rd_ptr_q <= wrap({1'b0, rd_ptr_q} + (PtrW+1)'(1));
      count_q  <= count_d;
    end
  end

  assign out_o.valid      = count_q != '0;
  assign out_o.out_byte   = mem_q[rd_ptr_q].out_byte;
  assign out_o.is_end     = mem_q[rd_ptr_q].is_end;
  assign out_o.end_status = mem_q[rd_ptr_q].end_status;

  // ---------------- assertions ----------------
  `UMV_ASSERT_NEVER(a_queue_bound, clk_i, rst_ni, count_q > CntW'(QueueDepth))
  `UMV_ASSERT_NEXT(a_count_track, clk_i, rst_ni, !pop,
                   count_q == $past(count_q) + CntW'($past(push.count)))
  `UMV_ASSERT_IMP(a_discard_idle, clk_i, rst_ni, st.discarding,
                  st.need_count == 2'd0 && st.held_count == 2'd0)
  `UMV_ASSERT_IMP(a_pending_held, clk_i, rst_ni, st.need_count != 2'd0,
                  st.held_count != 2'd0)

endmodule
